>>> rtl/core/rc4_pkg.sv
// Shared types, constants and state encoding for the RC4 stream cipher.
package rc4_pkg;

  localparam int SBOX_DEPTH  = 256;
  localparam int BYTE_W      = 8;
  localparam int KEY_MAX_DEF = 256;

  localparam logic [BYTE_W-1:0] SBOX_LAST = BYTE_W'(SBOX_DEPTH - 1);

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KRD,
    ST_KJ,
    ST_KW1,
    ST_KW2,
    ST_DJ,
    ST_DW1,
    ST_DOUT
  } rc4_state_t;

  // Access request for the S-box store: two read ports, one write port.
  typedef struct packed {
    logic [BYTE_W-1:0] ra;
    logic [BYTE_W-1:0] rb;
    logic              we;
    logic [BYTE_W-1:0] wa;
    logic [BYTE_W-1:0] wd;
    logic              clr;
  } sbox_req_t;

endpackage

>>> rtl/core/rc4_sbox_mem.sv
// S-box store: 256 bytes, two registered read ports, one write port, identity when unwritten.
module rc4_sbox_mem
  import rc4_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  sbox_req_t         req,
  output logic [BYTE_W-1:0] rd_a,
  output logic [BYTE_W-1:0] rd_b
);

  logic [BYTE_W-1:0]     mem [SBOX_DEPTH];
  logic [SBOX_DEPTH-1:0] vld_r;
  logic [BYTE_W-1:0]     a_data_r;
  logic [BYTE_W-1:0]     b_data_r;
  logic [BYTE_W-1:0]     a_addr_r;
  logic [BYTE_W-1:0]     b_addr_r;
  logic                  a_vld_r;
  logic                  b_vld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wa] <= req.wd;
    end
    a_data_r <= mem[req.ra];
    b_data_r <= mem[req.rb];
    a_addr_r <= req.ra;
    b_addr_r <= req.rb;
    a_vld_r  <= vld_r[req.ra];
    b_vld_r  <= vld_r[req.rb];
  end

  // An entry never written since reset or since the last clear reads as its own index.
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.wa] <= 1'b1;
    end
  end

  assign rd_a = a_vld_r ? a_data_r : a_addr_r;
  assign rd_b = b_vld_r ? b_data_r : b_addr_r;

endmodule

>>> rtl/core/rc4_key_mem.sv
// Key byte store with one write port and one registered read port.
module rc4_key_mem
  import rc4_pkg::*;
#(
  parameter int KEY_MAX = KEY_MAX_DEF,
  localparam int KAW    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [KAW-1:0]    waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic [KAW-1:0]    raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [KEY_MAX];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/rc4_core.sv
// Sequencer and shared byte adder driving the S-box and key stores.
module rc4_core
  import rc4_pkg::*;
#(
  parameter int KEY_MAX = KEY_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [BYTE_W-1:0] in_value,
  input  logic              in_last,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [BYTE_W-1:0] res_data,
  output logic              res_last
);

  localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int KCW = $clog2(KEY_MAX + 1);
  localparam logic [KCW-1:0] KEY_LIM = KCW'(KEY_MAX);

  rc4_state_t        state_r, state_nxt;
  logic [BYTE_W-1:0] i_r, i_nxt;
  logic [BYTE_W-1:0] j_r, j_nxt;
  logic [BYTE_W-1:0] si_r, si_nxt;
  logic [BYTE_W-1:0] sj_r, sj_nxt;
  logic [BYTE_W-1:0] t_r, t_nxt;
  logic              hit_i_r, hit_i_nxt;
  logic              hit_j_r, hit_j_nxt;
  logic [BYTE_W-1:0] val_r, val_nxt;
  logic              last_r, last_nxt;
  logic [KCW-1:0]    kc_r, kc_nxt;
  logic [KCW-1:0]    len_r, len_nxt;
  logic [KCW-1:0]    k_r, k_nxt;
  logic [KCW-1:0]    k_inc;

  logic [BYTE_W-1:0] opa, opb, opc, sum;
  sbox_req_t         sreq;
  logic [BYTE_W-1:0] rd_a, rd_b;
  logic              key_we;
  logic [BYTE_W-1:0] key_q;
  logic [BYTE_W-1:0] ks;

  rc4_sbox_mem u_sbox (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq),
    .rd_a  (rd_a),
    .rd_b  (rd_b)
  );

  rc4_key_mem #(
    .KEY_MAX (KEY_MAX)
  ) u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (kc_r[KAW-1:0]),
    .wdata (in_value),
    .raddr (k_r[KAW-1:0]),
    .rdata (key_q)
  );

  // Shared three-operand byte adder: j update in both phases, keystream index for data.
  assign sum   = opa + opb + opc;
  assign k_inc = k_r + KCW'(1);

  // After the swap, S[j] holds the old S[i] and S[i] holds the old S[j].
  assign ks       = hit_j_r ? si_r : (hit_i_r ? sj_r : rd_a);
  assign res_data = val_r ^ ks;
  assign res_last = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      kc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      kc_r    <= kc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r    <= si_nxt;
    sj_r    <= sj_nxt;
    t_r     <= t_nxt;
    hit_i_r <= hit_i_nxt;
    hit_j_r <= hit_j_nxt;
    val_r   <= val_nxt;
    last_r  <= last_nxt;
    len_r   <= len_nxt;
    k_r     <= k_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    si_nxt    = si_r;
    sj_nxt    = sj_r;
    t_nxt     = t_r;
    hit_i_nxt = hit_i_r;
    hit_j_nxt = hit_j_r;
    val_nxt   = val_r;
    last_nxt  = last_r;
    kc_nxt    = kc_r;
    len_nxt   = len_r;
    k_nxt     = k_r;
    opa       = j_r;
    opb       = rd_a;
    opc       = '0;
    sreq.ra   = i_r + BYTE_W'(1);
    sreq.rb   = j_r;
    sreq.we   = 1'b0;
    sreq.wa   = i_r;
    sreq.wd   = rd_b;
    sreq.clr  = 1'b0;
    key_we    = 1'b0;
    in_ready  = 1'b0;
    res_valid = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_DATA) begin
            // S[i+1] read is already under way on port A
            i_nxt     = i_r + BYTE_W'(1);
            val_nxt   = in_value;
            last_nxt  = in_last;
            state_nxt = ST_DJ;
          end else begin
            if (kc_r < KEY_LIM) begin
              key_we = 1'b1;
              kc_nxt = kc_r + KCW'(1);
            end
            if (in_last) begin
              len_nxt   = (kc_r < KEY_LIM) ? kc_r + KCW'(1) : kc_r;
              kc_nxt    = '0;
              sreq.clr  = 1'b1;
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              state_nxt = ST_KRD;
            end
          end
        end
      end

      ST_KRD: begin
        sreq.ra   = i_r;
        state_nxt = ST_KJ;
      end

      ST_KJ: begin
        opc       = key_q;
        j_nxt     = sum;
        si_nxt    = rd_a;
        sreq.rb   = sum;
        state_nxt = ST_KW1;
      end

      ST_KW1: begin
        sreq.we   = 1'b1;
        state_nxt = ST_KW2;
      end

      ST_KW2: begin
        sreq.we = 1'b1;
        sreq.wa = j_r;
        sreq.wd = si_r;
        i_nxt   = i_r + BYTE_W'(1);
        k_nxt   = (k_inc == len_r) ? '0 : k_inc;
        if (i_r == SBOX_LAST) begin
          j_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_KRD;
        end
      end

      ST_DJ: begin
        j_nxt     = sum;
        si_nxt    = rd_a;
        sreq.rb   = sum;
        state_nxt = ST_DW1;
      end

      ST_DW1: begin
        sreq.we   = 1'b1;
        opa       = si_r;
        opb       = rd_b;
        sreq.ra   = sum;
        t_nxt     = sum;
        sj_nxt    = rd_b;
        hit_i_nxt = (sum == i_r);
        hit_j_nxt = (sum == j_r);
        state_nxt = ST_DOUT;
      end

      ST_DOUT: begin
        // hold the read of S[t] and repeat the write while the output is stalled
        sreq.we   = 1'b1;
        sreq.wa   = j_r;
        sreq.wd   = si_r;
        sreq.ra   = t_r;
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/rc4_stream_cipher_top.sv
// RC4 stream cipher top level: byte sequencer and output register.
//
//   port group  dir  tdata          tuser          tlast
//   in_*        in   value [7:0]    kind (1=data)  last key / message byte
//   out_*       out  data_out [7:0] -              last_out
//
// A data byte passes ST_DJ, ST_DW1 and ST_DOUT before its result is registered;
// the S-box store has one write port, so the swap needs two writes after two
// dependent reads. A key byte without tlast leaves the block ready; the last key
// byte runs the key schedule over all 256 entries with in_tready low throughout.
// Reset (rst_n low, synchronous) restores the identity S-box and clears i, j
// and the key count. A result stalled at out_* holds the block in its last cycle.
module rc4_stream_cipher_top
  import rc4_pkg::*;
#(
  parameter int KEY_MAX = KEY_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,   // [7:0] value
  input  logic              in_tuser,   // [0] kind
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,  // [7:0] data_out
  output logic              out_tlast
);

  logic              res_valid;
  logic              res_ready;
  logic [BYTE_W-1:0] res_data;
  logic              res_last;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_last_r;

  rc4_core #(
    .KEY_MAX (KEY_MAX)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_value  (in_tdata),
    .in_last   (in_tlast),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .res_last  (res_last)
  );

  // Load a new beat when the register is empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == KIND_DATA) |=> !in_tready)
    else $error("block ready right after accepting a data beat");

  a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == KIND_KEY) && in_tlast |=> !in_tready)
    else $error("block ready right after the last key beat");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result beat appeared while the block was idle");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the RC4 stream cipher: directed beats, then random keys and messages.
module testbench;
  import rc4_pkg::*;

  localparam int IDLE_LIMIT   = 6000;
  localparam int HOLDOFF_LEN  = 300;
  localparam int RANDOM_BEATS = 1100;
  localparam int TAIL_CYCLES  = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } cipher_out_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              typed;
    cipher_out_t       want;
  } beat_t;

  // Known answers: identity S-box before any key, and the classic "Key"/"Plaintext" pair.
  localparam beat_t DIRECTED_BEATS [24] = '{
    '{KIND_DATA, 8'h00, 1'b0, 1'b1, '{8'h02, 1'b0}},
    '{KIND_DATA, 8'hFF, 1'b0, 1'b1, '{8'hFA, 1'b0}},
    '{KIND_DATA, 8'h80, 1'b1, 1'b1, '{8'h87, 1'b1}},
    '{KIND_KEY,  8'h4B, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{KIND_KEY,  8'h65, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{KIND_KEY,  8'h79, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{KIND_DATA, 8'h50, 1'b0, 1'b1, '{8'hBB, 1'b0}},
    '{KIND_DATA, 8'h6C, 1'b0, 1'b1, '{8'hF3, 1'b0}},
    '{KIND_DATA, 8'h61, 1'b0, 1'b1, '{8'h16, 1'b0}},
    '{KIND_DATA, 8'h69, 1'b0, 1'b1, '{8'hE8, 1'b0}},
    '{KIND_DATA, 8'h6E, 1'b0, 1'b1, '{8'hD9, 1'b0}},
    '{KIND_DATA, 8'h74, 1'b0, 1'b1, '{8'h40, 1'b0}},
    '{KIND_DATA, 8'h65, 1'b0, 1'b1, '{8'hAF, 1'b0}},
    '{KIND_DATA, 8'h78, 1'b0, 1'b1, '{8'h0A, 1'b0}},
    '{KIND_DATA, 8'h74, 1'b1, 1'b1, '{8'hD3, 1'b1}},
    '{KIND_KEY,  8'h00, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{KIND_DATA, 8'h00, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{KIND_DATA, 8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{KIND_KEY,  8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{KIND_DATA, 8'hA5, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{KIND_KEY,  8'h12, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{KIND_DATA, 8'h33, 1'b0, 1'b0, '{8'h00, 1'b0}},
    '{KIND_KEY,  8'hFF, 1'b1, 1'b0, '{8'h00, 1'b0}},
    '{KIND_DATA, 8'h00, 1'b1, 1'b0, '{8'h00, 1'b0}}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [BYTE_W-1:0] out_tdata;
  logic              out_tlast;

  rc4_stream_cipher_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state
  logic [BYTE_W-1:0] perm [SBOX_DEPTH];
  logic [BYTE_W-1:0] key_bytes [SBOX_DEPTH];
  logic [8:0]        key_len;
  logic [BYTE_W-1:0] ptr_i;
  logic [BYTE_W-1:0] ptr_j;

  beat_t       stim [$];
  cipher_out_t cipher_due [$];
  int          errors = 0;
  int          beats_sent = 0;
  int          results_seen = 0;
  int          schedules_run = 0;
  int          key_bytes_dropped = 0;
  int          holdoffs_done = 0;

  function automatic void rc4_clear();
    for (int n = 0; n < SBOX_DEPTH; n++) begin
      perm[n] = BYTE_W'(n);
      key_bytes[n] = '0;
    end
    key_len = '0;
    ptr_i = '0;
    ptr_j = '0;
  endfunction

  function automatic void swap_perm(logic [BYTE_W-1:0] a, logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] held;
    held = perm[a];
    perm[a] = perm[b];
    perm[b] = held;
  endfunction

  // Advance the cipher by one accepted beat; return 1 when it yields an output byte.
  function automatic bit rc4_advance(logic kind, logic [BYTE_W-1:0] value, logic last,
                                     output cipher_out_t res);
    int                klen;
    logic [BYTE_W-1:0] jj;
    logic [BYTE_W-1:0] t;
    res = '0;
    if (kind == KIND_KEY) begin
      if (key_len < KEY_MAX_DEF) begin
        key_bytes[key_len[BYTE_W-1:0]] = value;
        key_len++;
      end else begin
        key_bytes_dropped++;
      end
      if (last) begin
        klen = (key_len == 0) ? 1 : int'(key_len);
        for (int n = 0; n < SBOX_DEPTH; n++) perm[n] = BYTE_W'(n);
        jj = '0;
        for (int n = 0; n < SBOX_DEPTH; n++) begin
          jj = jj + perm[n] + key_bytes[n % klen];
          swap_perm(BYTE_W'(n), jj);
        end
        ptr_i = '0;
        ptr_j = '0;
        key_len = '0;
        schedules_run++;
      end
      return 1'b0;
    end
    ptr_i = ptr_i + 1'b1;
    ptr_j = ptr_j + perm[ptr_i];
    swap_perm(ptr_i, ptr_j);
    t = perm[ptr_i] + perm[ptr_j];
    res.data = value ^ perm[t];
    res.last = last;
    return 1'b1;
  endfunction

  task automatic add_beat(logic kind, logic [BYTE_W-1:0] value, logic last);
    beat_t b;
    b = '0;
    b.kind = kind;
    b.value = value;
    b.last = last;
    stim.push_back(b);
  endtask

  task automatic add_key(int len);
    for (int n = 0; n < len; n++) add_beat(KIND_KEY, BYTE_W'($urandom), n == len - 1);
  endtask

  task automatic add_message(int len);
    for (int n = 0; n < len; n++) add_beat(KIND_DATA, BYTE_W'($urandom), n == len - 1);
  endtask

  // Result checker
  always @(posedge clk) begin
    cipher_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (cipher_due.size() == 0) begin
        $error("result with nothing pending: data_out=%h last_out=%b", out_tdata, out_tlast);
        errors++;
      end else begin
        want = cipher_due.pop_front();
        if (out_tdata !== want.data) begin
          $error("data_out: expected %h, got %h", want.data, out_tdata);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_out: expected %b, got %b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // Receiver: shifting stall patterns, plus long hold-offs that back the block up
  initial begin
    int mode;
    int mode_left;
    int tick;
    int next_holdoff;
    mode = 0;
    mode_left = 0;
    tick = 0;
    next_holdoff = 150;
    forever begin
      @(posedge clk);
      tick++;
      if (rst_n && results_seen >= next_holdoff && holdoffs_done < 2) begin
        out_tready <= 1'b0;
        repeat (HOLDOFF_LEN) @(posedge clk);
        holdoffs_done++;
        next_holdoff = results_seen + 300;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (tick % 4 == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int          seq_no;
    int          made;
    int          pick;
    int          burst;
    int          gap;
    int          key_len_pick;
    beat_t       b;
    cipher_out_t res;
    rc4_clear();
    foreach (DIRECTED_BEATS[n]) stim.push_back(DIRECTED_BEATS[n]);

    // Random part: mostly key + message pairs, with some bare messages and noise
    seq_no = 0;
    made = 0;
    while (made < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (seq_no == 0) begin
        // overlong key: extra bytes dropped, last one still schedules
        add_key(KEY_MAX_DEF + $urandom_range(1, 6));
        add_message($urandom_range(4, 20));
        made += KEY_MAX_DEF + 20;
      end else if (seq_no == 1) begin
        add_key(KEY_MAX_DEF);
        add_message($urandom_range(4, 20));
        made += KEY_MAX_DEF + 20;
      end else if (pick < 75) begin
        key_len_pick = (pick < 10) ? $urandom_range(17, 80) : $urandom_range(1, 16);
        add_key(key_len_pick);
        gap = $urandom_range(1, 30);
        add_message(gap);
        made += key_len_pick + gap;
      end else if (pick < 90) begin
        gap = $urandom_range(1, 20);
        add_message(gap);
        made += gap;
      end else begin
        gap = $urandom_range(1, 10);
        for (int n = 0; n < gap; n++) begin
          add_beat(1'($urandom_range(0, 1)), BYTE_W'($urandom), $urandom_range(0, 5) == 0);
        end
        made += gap;
      end
      seq_no++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst = 0;
    while (stim.size() != 0) begin
      b = stim.pop_front();
      if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 24);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= b.value;
      in_tuser  <= b.kind;
      in_tlast  <= b.last;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      beats_sent++;
      if (rc4_advance(b.kind, b.value, b.last, res)) begin
        cipher_due.push_back(b.typed ? b.want : res);
      end
      burst--;
    end
    in_tvalid <= 1'b0;

    while (cipher_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d beats, %0d output bytes checked, %0d key schedules",
             beats_sent, results_seen, schedules_run);
    $display("dropped %0d key bytes past the key limit, %0d long receiver hold-offs",
             key_bytes_dropped, holdoffs_done);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rc4_pkg.sv
rtl/core/rc4_sbox_mem.sv
rtl/core/rc4_key_mem.sv
rtl/core/rc4_core.sv
rtl/core/rc4_stream_cipher_top.sv
tb/sv/testbench.sv
